// File: sv/zzp_pkg.sv
// Shared constants, types and record layouts for the zigzag pivot detector.
package zzp_pkg;

  // Series and sample sizing.
  localparam longint unsigned MAX_LEN = 64'd65536;
  localparam int SAMPLE_BITS = 32;

  // Fixed field widths.
  localparam int SAMPLE_W   = 32;
  localparam int IDX_W      = 16;
  localparam int UP_W       = 24;
  localparam int DOWN_W     = 17;
  localparam int FRAC_BITS  = 16;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;

  // Product widths for the ratio tests.
  localparam int UPROD_W = UP_W + SAMPLE_W;
  localparam int DPROD_W = DOWN_W + SAMPLE_W;

  // Highest position that the index can hold.
  localparam logic [IDX_W-1:0] IDX_LIMIT =
    (MAX_LEN - 64'd1 > 64'd65535) ? {IDX_W{1'b1}} : IDX_W'(MAX_LEN - 64'd1);

  // Mask that keeps the significant sample bits.
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
    (SAMPLE_BITS >= SAMPLE_W) ? {SAMPLE_W{1'b1}} :
    SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);

  // Register reset values.
  localparam logic [UP_W-1:0]   UP_RATIO_RST   = 24'd68813;
  localparam logic [DOWN_W-1:0] DOWN_RATIO_RST = 17'd62259;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UP_RATIO   = 2'd0,
    REG_DOWN_RATIO = 2'd1,
    REG_MARK_FIRST = 2'd2
  } cfg_reg_t;

  // Pivot kinds.
  localparam logic KIND_VALLEY = 1'b0;
  localparam logic KIND_PEAK   = 1'b1;

  // One result record.
  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             kind;
    logic             end_of_run;
    logic             overflowed;
  } pivot_rec_t;

  // All results caused by one input, packed from slot zero up.
  localparam int MAX_RESULTS = 3;
  localparam int RES_CNT_W   = 2;

  typedef struct packed {
    logic [RES_CNT_W-1:0]             count;
    pivot_rec_t [MAX_RESULTS-1:0]     recs;
  } bundle_t;

  // Queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

endpackage

// File: sv/zzp_front.sv
// Front end: configuration registers, series state and per-sample classification.
module zzp_front
  import zzp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_push,
  input  logic [SAMPLE_W-1:0]   in_sample,
  input  logic                  in_last,
  input  logic                  q_full,
  output logic                  bundle_push,
  output bundle_t               bundle
);

  // Configuration registers.
  logic [UP_W-1:0]   up_r;
  logic [DOWN_W-1:0] down_r;
  logic              mark_first_r;

  // Series state.
  logic                decided_r, decided_nxt;
  logic                trend_r, trend_nxt;
  logic                fe_r, fe_nxt;
  logic                so_r, so_nxt;
  logic [IDX_W-1:0]    cnt_r, cnt_nxt;
  logic [SAMPLE_W-1:0] fs_r, fs_nxt;
  logic [SAMPLE_W-1:0] pv_r, pv_nxt;
  logic [IDX_W-1:0]    pp_r, pp_nxt;
  logic [SAMPLE_W-1:0] min_v_r, min_v_nxt;
  logic [IDX_W-1:0]    min_p_r, min_p_nxt;
  logic [SAMPLE_W-1:0] max_v_r, max_v_nxt;
  logic [IDX_W-1:0]    max_p_r, max_p_nxt;

  // Step working signals.
  logic                 accept;
  logic [SAMPLE_W-1:0]  x;
  logic [IDX_W-1:0]     pos;
  logic                 first;
  logic [SAMPLE_W-1:0]  up_opnd, dn_opnd;
  logic [UPROD_W-1:0]   prod_up;
  logic [DPROD_W-1:0]   prod_dn;
  logic [UPROD_W-1:0]   x_scaled;
  logic                 rise_c, fall_c;
  logic                 hit;
  logic [RES_CNT_W-1:0] n;
  pivot_rec_t [MAX_RESULTS-1:0] recs;
  logic                 end_kind;

  // Index zero goes out at most once per series.
  function automatic logic may_emit(input logic [IDX_W-1:0] idx, input logic done0);
    return (idx != '0) || !done0;
  endfunction

  function automatic pivot_rec_t make_rec(input logic [IDX_W-1:0] idx, input logic kind,
                                          input logic ovf);
    pivot_rec_t r;
    r.index      = idx;
    r.kind       = kind;
    r.end_of_run = 1'b0;
    r.overflowed = ovf;
    return r;
  endfunction

  assign accept = in_push && !q_full;
  assign x      = in_sample & SAMPLE_MASK;
  assign pos    = so_r ? IDX_LIMIT : cnt_r;
  assign first  = (cnt_r == '0) && !so_r;

  // Ratio products against the stored reference values. Once decided, both test
  // the pivot; before that, the rise tests the running minimum and the fall the maximum.
  assign up_opnd  = decided_r ? pv_r : min_v_r;
  assign dn_opnd  = decided_r ? pv_r : max_v_r;
  assign prod_up  = UPROD_W'(up_r) * UPROD_W'(up_opnd);
  assign prod_dn  = DPROD_W'(down_r) * DPROD_W'(dn_opnd);
  assign x_scaled = UPROD_W'({x, {FRAC_BITS{1'b0}}});
  assign rise_c   = x_scaled >= prod_up;
  assign fall_c   = x_scaled <= UPROD_W'(prod_dn);

  // Classification of one sample and the results it causes.
  always_comb begin
    decided_nxt = decided_r;
    trend_nxt   = trend_r;
    fe_nxt      = fe_r;
    so_nxt      = so_r;
    cnt_nxt     = cnt_r;
    fs_nxt      = fs_r;
    pv_nxt      = pv_r;
    pp_nxt      = pp_r;
    min_v_nxt   = min_v_r;
    min_p_nxt   = min_p_r;
    max_v_nxt   = max_v_r;
    max_p_nxt   = max_p_r;
    n           = '0;
    recs        = '0;
    hit         = 1'b0;
    end_kind    = 1'b0;

    if (first) begin
      fs_nxt    = x;
      min_v_nxt = x;
      min_p_nxt = '0;
      max_v_nxt = x;
      max_p_nxt = '0;
    end else if (!decided_r) begin
      if (rise_c) begin
        hit       = 1'b1;
        trend_nxt = (min_p_r != '0);
      end else if (fall_c) begin
        hit       = 1'b1;
        trend_nxt = (max_p_r == '0);
      end else begin
        if (x > max_v_r) begin
          max_v_nxt = x;
          max_p_nxt = pos;
        end
        if (x < min_v_r) begin
          min_v_nxt = x;
          min_p_nxt = pos;
        end
      end
      // The first decision takes the running extreme of the new trend as the pivot.
      if (hit) begin
        decided_nxt = 1'b1;
        pv_nxt      = trend_nxt ? max_v_r : min_v_r;
        pp_nxt      = trend_nxt ? max_p_r : min_p_r;
        if (mark_first_r && may_emit('0, fe_nxt)) begin
          fe_nxt  = 1'b1;
          recs[n] = make_rec('0, trend_nxt, so_r);
          n       = n + 2'd1;
        end
      end
    end

    // Tracking of the extreme since the last pivot. The pivot after a fresh
    // decision equals the operand that the matching test already used.
    if (!first && (decided_r || hit)) begin
      if (trend_nxt) begin
        if (fall_c) begin
          if (may_emit(pp_nxt, fe_nxt)) begin
            fe_nxt  = fe_nxt | (pp_nxt == '0);
            recs[n] = make_rec(pp_nxt, KIND_PEAK, so_r);
            n       = n + 2'd1;
          end
          trend_nxt = 1'b0;
          pv_nxt    = x;
          pp_nxt    = pos;
        end else if (x > pv_nxt) begin
          pv_nxt = x;
          pp_nxt = pos;
        end
      end else begin
        if (rise_c) begin
          if (may_emit(pp_nxt, fe_nxt)) begin
            fe_nxt  = fe_nxt | (pp_nxt == '0);
            recs[n] = make_rec(pp_nxt, KIND_VALLEY, so_r);
            n       = n + 2'd1;
          end
          trend_nxt = 1'b1;
          pv_nxt    = x;
          pp_nxt    = pos;
        end else if (x < pv_nxt) begin
          pv_nxt = x;
          pp_nxt = pos;
        end
      end
    end

    if (in_last) begin
      // A series that ends undecided picks its trend from first against final sample.
      if (!decided_nxt) begin
        trend_nxt = !(fs_nxt < x);
        pp_nxt    = trend_nxt ? max_p_nxt : min_p_nxt;
        if (mark_first_r && may_emit('0, fe_nxt)) begin
          fe_nxt  = 1'b1;
          recs[n] = make_rec('0, trend_nxt, so_r);
          n       = n + 2'd1;
        end
      end
      // End mark on the final sample.
      end_kind = (pp_nxt == pos) ? trend_nxt : !trend_nxt;
      if (may_emit(pos, fe_nxt)) begin
        fe_nxt  = fe_nxt | (pos == '0);
        recs[n] = make_rec(pos, end_kind, so_r);
        n       = n + 2'd1;
      end
      if (n != '0) begin
        recs[n - 2'd1].end_of_run = 1'b1;
      end
      // Clear the series for the next one.
      decided_nxt = 1'b0;
      trend_nxt   = 1'b0;
      fe_nxt      = 1'b0;
      so_nxt      = 1'b0;
      cnt_nxt     = '0;
      fs_nxt      = '0;
      pv_nxt      = '0;
      pp_nxt      = '0;
      min_v_nxt   = '0;
      min_p_nxt   = '0;
      max_v_nxt   = '0;
      max_p_nxt   = '0;
    end else begin
      if (n != '0) begin
        recs[n - 2'd1].end_of_run = 1'b1;
      end
      // The position counter saturates at the index limit.
      if (!so_r) begin
        if (cnt_r >= IDX_LIMIT) begin
          so_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
    end
  end

  assign bundle_push  = accept && (n != '0);
  assign bundle.count = n;
  assign bundle.recs  = recs;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_r         <= UP_RATIO_RST;
      down_r       <= DOWN_RATIO_RST;
      mark_first_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_UP_RATIO:   up_r         <= cfg_data[UP_W-1:0];
        REG_DOWN_RATIO: down_r       <= cfg_data[DOWN_W-1:0];
        REG_MARK_FIRST: mark_first_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Series state update on every accepted sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decided_r <= 1'b0;
      trend_r   <= 1'b0;
      fe_r      <= 1'b0;
      so_r      <= 1'b0;
      cnt_r     <= '0;
      fs_r      <= '0;
      pv_r      <= '0;
      pp_r      <= '0;
      min_v_r   <= '0;
      min_p_r   <= '0;
      max_v_r   <= '0;
      max_p_r   <= '0;
    end else if (accept) begin
      decided_r <= decided_nxt;
      trend_r   <= trend_nxt;
      fe_r      <= fe_nxt;
      so_r      <= so_nxt;
      cnt_r     <= cnt_nxt;
      fs_r      <= fs_nxt;
      pv_r      <= pv_nxt;
      pp_r      <= pp_nxt;
      min_v_r   <= min_v_nxt;
      min_p_r   <= min_p_nxt;
      max_v_r   <= max_v_nxt;
      max_p_r   <= max_p_nxt;
    end
  end

endmodule

// File: sv/zzp_queue.sv
// Short queue of result groups between the front end and the output stage.
module zzp_queue
  import zzp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t din,
  input  logic    pop,
  output bundle_t dout,
  output logic    full,
  output logic    empty
);

  bundle_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  // Pointer and fill count bookkeeping.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// File: sv/zzp_back.sv
// Output stage: holds one result group and hands out its records one per request.
module zzp_back
  import zzp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  bundle_t          q_head,
  output logic             q_pop,
  input  logic             out_pop,
  output logic             out_empty,
  output logic [IDX_W-1:0] out_pivot_index,
  output logic             out_pivot_kind,
  output logic             out_end_of_run,
  output logic             out_overflowed
);

  bundle_t              hold_r, hold_nxt;
  logic                 hold_v_r, hold_v_nxt;
  logic [RES_CNT_W-1:0] sel_r, sel_nxt;
  logic                 pop_ok, last_sel, need_load;
  pivot_rec_t           cur;

  assign pop_ok    = out_pop && hold_v_r;
  assign last_sel  = (sel_r == hold_r.count - 2'd1);
  assign need_load = !hold_v_r || (pop_ok && last_sel);
  assign q_pop     = need_load && !q_empty;

  // Move to the next record, or fetch the next group once this one is done.
  always_comb begin
    hold_nxt   = hold_r;
    hold_v_nxt = hold_v_r;
    sel_nxt    = sel_r;
    if (need_load) begin
      hold_v_nxt = !q_empty;
      sel_nxt    = '0;
      if (!q_empty) begin
        hold_nxt = q_head;
      end
    end else if (pop_ok) begin
      sel_nxt = sel_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      sel_r    <= '0;
    end else begin
      hold_v_r <= hold_v_nxt;
      sel_r    <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
  end

  // Current record on the result ports.
  assign cur             = hold_r.recs[sel_r];
  assign out_empty       = !hold_v_r;
  assign out_pivot_index = cur.index;
  assign out_pivot_kind  = cur.kind;
  assign out_end_of_run  = cur.end_of_run;
  assign out_overflowed  = cur.overflowed;

endmodule

// File: sv/zigzag_pivot_detector.sv
// Top level of the zigzag pivot detector: front end, group queue and output stage.
//
//   channel  direction  handshake        payload
//   in_      input      in_push/in_full   in_sample[31:0], in_last
//   out_     output     out_empty/out_pop out_pivot_index[15:0], out_pivot_kind,
//                                         out_end_of_run, out_overflowed
//   cfg_     input      cfg_we            cfg_index[1:0], cfg_data[23:0]
//
// A sample is classified in the cycle it is accepted, one per cycle while in_full
// is low; the ratio multiply and compare against stored values sets that cycle.
// Results are registered in the group queue, then in the output stage. The output
// stage delivers one result per cycle while out_pop is high, so samples that cause
// two or three results fill the four-group queue; in_full rises only when full.
// Synchronous active-low reset clears all state and restores the register defaults.
module zigzag_pivot_detector
  import zzp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [SAMPLE_W-1:0]   in_sample,
  input  logic                  in_last,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [IDX_W-1:0]      out_pivot_index,
  output logic                  out_pivot_kind,
  output logic                  out_end_of_run,
  output logic                  out_overflowed
);

  logic    bundle_push;
  bundle_t bundle;
  bundle_t q_head;
  logic    q_pop, q_full, q_empty;

  assign in_full = q_full;

  zzp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_push     (in_push),
    .in_sample   (in_sample),
    .in_last     (in_last),
    .q_full      (q_full),
    .bundle_push (bundle_push),
    .bundle      (bundle)
  );

  zzp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (bundle_push),
    .din   (bundle),
    .pop   (q_pop),
    .dout  (q_head),
    .full  (q_full),
    .empty (q_empty)
  );

  zzp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_pop         (out_pop),
    .out_empty       (out_empty),
    .out_pivot_index (out_pivot_index),
    .out_pivot_kind  (out_pivot_kind),
    .out_end_of_run  (out_end_of_run),
    .out_overflowed  (out_overflowed)
  );

  // An idle output stage picks up a waiting group in the next cycle.
  a_back_loads : assert property (@(posedge clk) disable iff (!rst_n)
    (!q_empty && out_empty) |=> !out_empty)
    else $error("output stage did not load a waiting result group");

  // A group written by the front end is in the queue in the next cycle.
  a_group_queued : assert property (@(posedge clk) disable iff (!rst_n)
    bundle_push |=> !q_empty)
    else $error("result group was lost on its way into the queue");

  // A stored group always holds at least one result.
  a_group_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    bundle_push |-> (bundle.count != '0))
    else $error("empty result group written to the queue");

  // Reset leaves both channels idle.
  a_reset_idle : assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("channels not idle after reset");

endmodule
